// File: sv/gnss_channel_tracking_loop_core_macros.svh
// Assertion helpers for the channel tracking loop.
// Both expect signals named clk and rst_n in the asserting scope.
`ifndef GNSS_CHANNEL_TRACKING_LOOP_CORE_MACROS_SVH
`define GNSS_CHANNEL_TRACKING_LOOP_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define GCTL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define GCTL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/gctl_pkg.sv
package gctl_pkg;

  // Field and state widths.
  localparam int RAW_W      = 16;
  localparam int SMP_W      = 14;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int HCC_W      = 11;
  localparam int BIN_W      = 5;
  localparam int PIC_W      = 12;

  // Search geometry.
  localparam logic [BIN_W-1:0] SEARCH_BINS    = 5'd20;
  localparam logic [HCC_W-1:0] HALF_CHIP_SPAN = 11'd2045;
  localparam logic [PIC_W-1:0] PULL_IN_MAX    = 12'hFFF;

  // Lock codes; each level includes the ones below it.
  localparam logic [2:0] LOCK_NONE    = 3'b000;
  localparam logic [2:0] LOCK_CODE    = 3'b001;
  localparam logic [2:0] LOCK_CARRIER = 3'b011;
  localparam logic [2:0] LOCK_PHASE   = 3'b111;

  // Register reset values.
  localparam logic        RST_CARRIER_POSITIVE    = 1'b0;
  localparam logic [27:0] RST_ACQUIRE_THRESHOLD   = 28'd214400;
  localparam logic [27:0] RST_LOSS_THRESHOLD      = 28'd26800;
  localparam logic [11:0] RST_PULL_IN_LIMIT       = 12'd3000;
  localparam logic [31:0] RST_CODE_REFERENCE      = 32'd13730473;
  localparam logic [31:0] RST_CARRIER_REFERENCE   = 32'd34628173;
  localparam logic [15:0] RST_CODE_SEARCH_STEP    = 16'd4;
  localparam logic [15:0] RST_CARRIER_SEARCH_STEP = 16'd6711;
  localparam logic [31:0] RST_CARRIER_NCO =
    RST_CARRIER_REFERENCE + {15'd0, RST_CARRIER_SEARCH_STEP, 1'b0};

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CARRIER_POSITIVE    = 3'd0,
    CFG_ACQUIRE_THRESHOLD   = 3'd1,
    CFG_LOSS_THRESHOLD      = 3'd2,
    CFG_PULL_IN_LIMIT       = 3'd3,
    CFG_CODE_REFERENCE      = 3'd4,
    CFG_CARRIER_REFERENCE   = 3'd5,
    CFG_CODE_SEARCH_STEP    = 3'd6,
    CFG_CARRIER_SEARCH_STEP = 3'd7
  } cfg_reg_e;

  typedef logic signed [RAW_W-1:0] raw_t;
  typedef logic signed [SMP_W-1:0] smp_t;

  typedef struct packed {
    logic        carrier_positive;
    logic [27:0] acquire_threshold;
    logic [27:0] loss_threshold;
    logic [11:0] pull_in_limit;
    logic [31:0] code_reference;
    logic [31:0] carrier_reference;
    logic [15:0] code_search_step;
    logic [15:0] carrier_search_step;
  } cfg_t;

  typedef struct packed {
    raw_t i_early;
    raw_t q_early;
    raw_t i_punctual;
    raw_t q_punctual;
    raw_t i_late;
    raw_t q_late;
  } in_beat_t;

  // Products handed from the correlator stage to the loop stage.
  typedef struct packed {
    logic signed [28:0] pc;
    logic signed [28:0] pcar;
    logic signed [28:0] fll;
    logic signed [29:0] dll;
    smp_t               ip;
    smp_t               qp;
  } prod_t;

  typedef struct packed {
    logic [31:0] carrier_word;
    logic [31:0] code_word;
    logic [2:0]  lock_flags;
    logic        slew_request;
    logic        search_exhausted;
  } res_t;

  // Stage load strobes.
  typedef struct packed {
    logic s0_load;
    logic s1_load;
    logic out_load;
  } pipe_ctl_t;

endpackage

// File: sv/gctl_in_if.sv
interface gctl_in_if;
  import gctl_pkg::*;

  logic valid;
  logic ready;
  raw_t i_early;
  raw_t q_early;
  raw_t i_punctual;
  raw_t q_punctual;
  raw_t i_late;
  raw_t q_late;

  modport source (
    output valid, i_early, q_early, i_punctual, q_punctual, i_late, q_late,
    input  ready
  );
  modport sink (
    input  valid, i_early, q_early, i_punctual, q_punctual, i_late, q_late,
    output ready
  );
endinterface

// File: sv/gctl_out_if.sv
interface gctl_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] carrier_word;
  logic [31:0] code_word;
  logic [2:0]  lock_flags;
  logic        slew_request;
  logic        search_exhausted;

  modport source (
    output valid, carrier_word, code_word, lock_flags, slew_request, search_exhausted,
    input  ready
  );
  modport sink (
    input  valid, carrier_word, code_word, lock_flags, slew_request, search_exhausted,
    output ready
  );
endinterface

// File: sv/gctl_front.sv
module gctl_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  gctl_pkg::pipe_ctl_t  ctl,
  input  gctl_pkg::in_beat_t   beat,
  output gctl_pkg::prod_t      prod
);
  import gctl_pkg::*;

  typedef struct packed {
    smp_t ie;
    smp_t qe;
    smp_t ip;
    smp_t qp;
    smp_t il;
    smp_t ql;
    smp_t lpi;
    smp_t lpq;
  } stg0_t;

  stg0_t s0_r;
  smp_t  lpi_r;
  smp_t  lpq_r;
  prod_t s1_r;
  prod_t s1_nxt;

  logic signed [28:0] ip29, qp29, lpi29, lpq29;
  logic signed [14:0] de15, dq15;
  logic signed [29:0] ip30, qp30, de30, dq30;

  // Arithmetic shift right by two keeps the top 14 bits.
  function automatic smp_t to_smp(raw_t v);
    return v[RAW_W-1:2];
  endfunction

  // Previous prompt, carried with each beat so products line up with it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lpi_r <= '0;
      lpq_r <= '0;
    end else if (ctl.s0_load) begin
      lpi_r <= to_smp(beat.i_punctual);
      lpq_r <= to_smp(beat.q_punctual);
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (ctl.s0_load) begin
      s0_r.ie  <= to_smp(beat.i_early);
      s0_r.qe  <= to_smp(beat.q_early);
      s0_r.ip  <= to_smp(beat.i_punctual);
      s0_r.qp  <= to_smp(beat.q_punctual);
      s0_r.il  <= to_smp(beat.i_late);
      s0_r.ql  <= to_smp(beat.q_late);
      s0_r.lpi <= lpi_r;
      s0_r.lpq <= lpq_r;
    end
  end

  // Powers and discriminator products.
  always_comb begin
    ip29  = 29'(s0_r.ip);
    qp29  = 29'(s0_r.qp);
    lpi29 = 29'(s0_r.lpi);
    lpq29 = 29'(s0_r.lpq);
    de15  = 15'(s0_r.ie) - 15'(s0_r.il);
    dq15  = 15'(s0_r.qe) - 15'(s0_r.ql);
    ip30  = 30'(s0_r.ip);
    qp30  = 30'(s0_r.qp);
    de30  = 30'(de15);
    dq30  = 30'(dq15);

    s1_nxt.pc   = ip29 * ip29 + qp29 * qp29;
    s1_nxt.pcar = ip29 * lpi29 + qp29 * lpq29;
    s1_nxt.fll  = qp29 * lpi29 - ip29 * lpq29;
    s1_nxt.dll  = de30 * ip30 + dq30 * qp30;
    s1_nxt.ip   = s0_r.ip;
    s1_nxt.qp   = s0_r.qp;
  end

  always_ff @(posedge clk) begin
    if (ctl.s1_load) begin
      s1_r <= s1_nxt;
    end
  end

  assign prod = s1_r;

endmodule

// File: sv/gctl_loop.sv
module gctl_loop (
  input  logic                 clk,
  input  logic                 rst_n,
  input  gctl_pkg::pipe_ctl_t  ctl,
  input  gctl_pkg::cfg_t       cfg,
  input  gctl_pkg::prod_t      prod,
  output gctl_pkg::res_t       res
);
  import gctl_pkg::*;

  // Loop state.
  logic [2:0]         lock_r,  lock_nxt;
  logic signed [29:0] cpa_r,   cpa_nxt;
  logic signed [29:0] capa_r,  capa_nxt;
  logic signed [25:0] pm_r,    pm_nxt;
  logic signed [37:0] dm_r,    dm_nxt;
  logic [PIC_W-1:0]   pic_r,   pic_nxt;
  logic [HCC_W-1:0]   hcc_r,   hcc_nxt;
  logic [BIN_W-1:0]   bin_r,   bin_nxt;
  logic [31:0]        cnco_r,  cnco_nxt;
  logic [31:0]        knco_r,  knco_nxt;
  res_t               res_r,   res_nxt;

  logic signed [29:0] acq_s, loss_s, pc_s, pcar_s;
  logic signed [31:0] c_dlt, k_dlt;
  logic               pull_done;
  logic signed [14:0] ip15, pll_disc;
  logic signed [25:0] pll_err;
  logic signed [27:0] pll_diff;
  logic signed [31:0] dcarr;
  logic signed [37:0] dll_err;
  logic signed [39:0] dll_diff;
  logic signed [31:0] dcode;
  logic [BIN_W-1:0]   off_mag;
  logic [31:0]        code_off, car_off;
  logic               slew, exh;

  always_comb begin
    acq_s  = $signed({2'b00, cfg.acquire_threshold});
    loss_s = $signed({2'b00, cfg.loss_threshold});
    pc_s   = 30'(prod.pc);
    pcar_s = 30'(prod.pcar);
    c_dlt  = 32'(pc_s) - 32'(cpa_r) + 32'sd128;
    k_dlt  = 32'(pcar_s) - 32'(capa_r) + 32'sd128;

    lock_nxt  = lock_r;
    cpa_nxt   = cpa_r;
    capa_nxt  = capa_r;
    pm_nxt    = pm_r;
    dm_nxt    = dm_r;
    pic_nxt   = pic_r;
    hcc_nxt   = hcc_r;
    bin_nxt   = bin_r;
    cnco_nxt  = cnco_r;
    knco_nxt  = knco_r;
    pull_done = 1'b0;
    ip15      = 15'(prod.ip);
    pll_disc  = '0;
    pll_err   = '0;
    pll_diff  = '0;
    dcarr     = '0;
    dll_err   = '0;
    dll_diff  = '0;
    dcode     = '0;
    off_mag   = '0;
    code_off  = '0;
    car_off   = '0;
    slew      = 1'b0;
    exh       = 1'b0;

    // Power averaging with a 1/256 leak while code locked.
    if (lock_r[0]) begin
      cpa_nxt  = cpa_r + 30'(c_dlt >>> 8);
      capa_nxt = capa_r + 30'(k_dlt >>> 8);
    end

    // Code lock on instantaneous power, loss on averaged power.
    if (pc_s > acq_s && !lock_r[0]) begin
      lock_nxt = LOCK_CODE;
      cpa_nxt  = loss_s;
      capa_nxt = loss_s;
      dm_nxt   = '0;
    end else if (cpa_nxt < loss_s) begin
      lock_nxt = LOCK_NONE;
    end

    // Carrier lock on averaged dot-product power.
    if (lock_nxt[0]) begin
      if (capa_nxt > acq_s && !lock_nxt[1]) begin
        lock_nxt = LOCK_CARRIER;
        pic_nxt  = '0;
      end else if (capa_nxt < loss_s) begin
        lock_nxt = LOCK_CODE;
      end
    end

    // Pull-in count toward phase lock; compare uses the count before the bump.
    if (lock_nxt[1] && !lock_nxt[2]) begin
      pull_done = (pic_nxt >= cfg.pull_in_limit);
      if (pic_nxt != PULL_IN_MAX) begin
        pic_nxt = pic_nxt + 1'b1;
      end
      if (pull_done) begin
        lock_nxt = LOCK_PHASE;
        pm_nxt   = '0;
      end
    end

    if (lock_nxt[0]) begin
      // FLL-aided PLL.
      if (prod.qp > 14'sd0) begin
        pll_disc = -ip15;
      end else if (prod.qp < 14'sd0) begin
        pll_disc = ip15;
      end
      pll_err  = 26'(pll_disc) <<< 11;
      pll_diff = 28'(pll_err) - 28'(pm_nxt) + ((28'(pll_err) + 28'sd16) >>> 5);
      pm_nxt   = pll_err;
      dcarr    = ((32'(prod.fll) + 32'sd8192) >>> 14)
               - ((32'(pll_diff) + 32'sd16384) >>> 15);
      if (cfg.carrier_positive) begin
        cnco_nxt = cnco_r + $unsigned(dcarr);
      end else begin
        cnco_nxt = cnco_r - $unsigned(dcarr);
      end

      // Early-minus-late DLL.
      dll_err  = 38'(prod.dll) <<< 7;
      dll_diff = 40'(dll_err) - 40'(dm_nxt) + ((40'(dll_err) + 40'sd256) >>> 9);
      dm_nxt   = dll_err;
      dcode    = 32'((dll_diff + 40'sd524288) >>> 20);
      knco_nxt = knco_r + $unsigned(dcode);
    end else begin
      // Search: slew half a chip, step bins after a full code sweep.
      slew = 1'b1;
      if (hcc_r >= HALF_CHIP_SPAN) begin
        hcc_nxt = '0;
        if (bin_r >= SEARCH_BINS) begin
          lock_nxt = LOCK_NONE;
          cpa_nxt  = loss_s;
          capa_nxt = loss_s;
          pm_nxt   = '0;
          dm_nxt   = '0;
          pic_nxt  = '0;
          bin_nxt  = '0;
          exh      = 1'b1;
        end else begin
          bin_nxt = bin_r + 1'b1;
        end
        // Odd bins sit above the reference, even bins at or below it.
        if (bin_nxt[0]) begin
          off_mag = (bin_nxt >> 1) + 1'b1;
        end else begin
          off_mag = bin_nxt >> 1;
        end
        code_off = 32'(cfg.code_search_step * off_mag);
        car_off  = 32'(cfg.carrier_search_step * off_mag);
        if (bin_nxt[0]) begin
          knco_nxt = cfg.code_reference + code_off;
          cnco_nxt = cfg.carrier_reference + car_off;
        end else begin
          knco_nxt = cfg.code_reference - code_off;
          cnco_nxt = cfg.carrier_reference - car_off;
        end
      end else begin
        hcc_nxt = hcc_r + 1'b1;
      end
    end

    res_nxt.carrier_word     = cnco_nxt | {cfg.carrier_positive, 31'd0};
    res_nxt.code_word        = knco_nxt;
    res_nxt.lock_flags       = lock_nxt;
    res_nxt.slew_request     = slew;
    res_nxt.search_exhausted = exh;
  end

  // State registers advance once per beat leaving the product stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lock_r <= LOCK_NONE;
      cpa_r  <= $signed({2'b00, RST_LOSS_THRESHOLD});
      capa_r <= $signed({2'b00, RST_LOSS_THRESHOLD});
      pm_r   <= '0;
      dm_r   <= '0;
      pic_r  <= '0;
      hcc_r  <= '0;
      bin_r  <= '0;
      cnco_r <= RST_CARRIER_NCO;
      knco_r <= RST_CODE_REFERENCE;
    end else if (ctl.out_load) begin
      lock_r <= lock_nxt;
      cpa_r  <= cpa_nxt;
      capa_r <= capa_nxt;
      pm_r   <= pm_nxt;
      dm_r   <= dm_nxt;
      pic_r  <= pic_nxt;
      hcc_r  <= hcc_nxt;
      bin_r  <= bin_nxt;
      cnco_r <= cnco_nxt;
      knco_r <= knco_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

// File: sv/gnss_channel_tracking_loop_core.sv
// Channel  Port      Beat contents
// -------  --------  ---------------------------------------------------------
// input    in_chan   early, prompt and late I/Q correlator dump, 16-bit signed
// result   out_chan  carrier and code NCO words, lock flags, slew, exhaustion
// config   cfg_*     write enable, register index, 32-bit write data
//
// One dump per clock sustained while out_chan is ready; a result passes through
// the input register, product register and result register.
// The rate is set by the loop-state update, whose next state is computed combinationally.
// Reset is synchronous on rst_n and loads the loop state from register defaults.
// When out_chan stalls the three stages fill before in_chan.ready drops.
`include "gnss_channel_tracking_loop_core_macros.svh"

module gnss_channel_tracking_loop_core (
  input  logic                               clk,
  input  logic                               rst_n,
  gctl_in_if.sink                            in_chan,
  gctl_out_if.source                         out_chan,
  input  logic                               cfg_we,
  input  logic [gctl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gctl_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import gctl_pkg::*;

  cfg_t      cfg_r;
  logic      s0_v_r, s1_v_r, out_v_r;
  logic      s0_en, s1_en, out_en;
  pipe_ctl_t ctl;
  in_beat_t  beat;
  prod_t     prod;
  res_t      res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.carrier_positive    <= RST_CARRIER_POSITIVE;
      cfg_r.acquire_threshold   <= RST_ACQUIRE_THRESHOLD;
      cfg_r.loss_threshold      <= RST_LOSS_THRESHOLD;
      cfg_r.pull_in_limit       <= RST_PULL_IN_LIMIT;
      cfg_r.code_reference      <= RST_CODE_REFERENCE;
      cfg_r.carrier_reference   <= RST_CARRIER_REFERENCE;
      cfg_r.code_search_step    <= RST_CODE_SEARCH_STEP;
      cfg_r.carrier_search_step <= RST_CARRIER_SEARCH_STEP;
    end else if (cfg_we) begin
      case (cfg_reg_e'(cfg_index))
        CFG_CARRIER_POSITIVE:    cfg_r.carrier_positive    <= cfg_data[0];
        CFG_ACQUIRE_THRESHOLD:   cfg_r.acquire_threshold   <= cfg_data[27:0];
        CFG_LOSS_THRESHOLD:      cfg_r.loss_threshold      <= cfg_data[27:0];
        CFG_PULL_IN_LIMIT:       cfg_r.pull_in_limit       <= cfg_data[11:0];
        CFG_CODE_REFERENCE:      cfg_r.code_reference      <= cfg_data[31:0];
        CFG_CARRIER_REFERENCE:   cfg_r.carrier_reference   <= cfg_data[31:0];
        CFG_CODE_SEARCH_STEP:    cfg_r.code_search_step    <= cfg_data[15:0];
        CFG_CARRIER_SEARCH_STEP: cfg_r.carrier_search_step <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Stage enables: a stage loads when it is empty or its contents move on.
  assign out_en = !out_v_r || out_chan.ready;
  assign s1_en  = !s1_v_r || out_en;
  assign s0_en  = !s0_v_r || s1_en;

  assign ctl.s0_load  = in_chan.valid && s0_en;
  assign ctl.s1_load  = s0_v_r && s1_en;
  assign ctl.out_load = s1_v_r && out_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r  <= 1'b0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s0_en) begin
        s0_v_r <= in_chan.valid;
      end
      if (s1_en) begin
        s1_v_r <= s0_v_r;
      end
      if (out_en) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  // Input beat.
  assign in_chan.ready   = s0_en;
  assign beat.i_early    = in_chan.i_early;
  assign beat.q_early    = in_chan.q_early;
  assign beat.i_punctual = in_chan.i_punctual;
  assign beat.q_punctual = in_chan.q_punctual;
  assign beat.i_late     = in_chan.i_late;
  assign beat.q_late     = in_chan.q_late;

  gctl_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .beat  (beat),
    .prod  (prod)
  );

  gctl_loop u_loop (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .cfg   (cfg_r),
    .prod  (prod),
    .res   (res)
  );

  // Result beat.
  assign out_chan.valid            = out_v_r;
  assign out_chan.carrier_word     = res.carrier_word;
  assign out_chan.code_word        = res.code_word;
  assign out_chan.lock_flags       = res.lock_flags;
  assign out_chan.slew_request     = res.slew_request;
  assign out_chan.search_exhausted = res.search_exhausted;

  // Slew is requested exactly when code lock is absent.
  `GCTL_ASSERT_NOW(a_slew_vs_lock, out_v_r, (res.slew_request == !res.lock_flags[0]), "slew request disagrees with code lock")
  // An exhausted search leaves the channel unlocked and slewing.
  `GCTL_ASSERT_NOW(a_exhaust_clear, (out_v_r && res.search_exhausted), ((res.lock_flags == LOCK_NONE) && res.slew_request), "exhaustion without channel reset")
  // A product beat moving on always shows up as a result.
  `GCTL_ASSERT_NEXT(a_result_follows, ctl.out_load, out_v_r, "result lost after product stage")
  // A result only appears from a filled product stage.
  `GCTL_ASSERT_NOW(a_result_source, $rose(out_v_r), $past(s1_v_r), "result without a product beat")

endmodule
